// ===== hw/rtl/dte_pkg.sv =====
// Shared types, constants and the token bit-count table for the DCT token expander.
`timescale 1ns / 1ps

package dte_pkg;

  localparam int unsigned TokRun1First = 23;
  localparam int unsigned LastPos      = 63;
  localparam int unsigned PosEnd       = 64;
  localparam int unsigned Cat8Min      = 69;
  localparam int unsigned Cat7Min      = 37;
  localparam int unsigned Cat6Min      = 21;

  localparam int unsigned TokenW = 5;
  localparam int unsigned BitsW  = 12;
  localparam int unsigned IndexW = 6;
  localparam int unsigned CountW = 4;
  localparam int unsigned NextW  = 7;
  localparam int unsigned MagW   = 10;
  localparam int unsigned ValueW = 11;

  typedef enum logic [TokenW-1:0] {
    TOK_EOB_0    = 5'd0,
    TOK_EOB_1    = 5'd1,
    TOK_EOB_2    = 5'd2,
    TOK_EOB_B2   = 5'd3,
    TOK_EOB_B3   = 5'd4,
    TOK_EOB_B4   = 5'd5,
    TOK_EOB_B12  = 5'd6,
    TOK_ZRUN_B3  = 5'd7,
    TOK_ZRUN_B6  = 5'd8,
    TOK_ONE_P    = 5'd9,
    TOK_ONE_N    = 5'd10,
    TOK_TWO_P    = 5'd11,
    TOK_TWO_N    = 5'd12,
    TOK_VAL3     = 5'd13,
    TOK_VAL4     = 5'd14,
    TOK_VAL5     = 5'd15,
    TOK_VAL6     = 5'd16,
    TOK_CAT3     = 5'd17,
    TOK_CAT4     = 5'd18,
    TOK_CAT5     = 5'd19,
    TOK_CAT6     = 5'd20,
    TOK_CAT7     = 5'd21,
    TOK_CAT8     = 5'd22,
    TOK_RUN1     = 5'd23,
    TOK_RUN2     = 5'd24,
    TOK_RUN3     = 5'd25,
    TOK_RUN4     = 5'd26,
    TOK_RUN5     = 5'd27,
    TOK_RUN6_B2  = 5'd28,
    TOK_RUN10_B3 = 5'd29,
    TOK_RUN1_V2  = 5'd30,
    TOK_RUN2_V2  = 5'd31
  } token_e;

  typedef enum logic [1:0] {
    TC_EOB,
    TC_ZRUN,
    TC_COEF
  } tok_class_e;

  // After decode: class, bit count, masked extra bits.
  typedef struct packed {
    token_e              token;
    tok_class_e          tclass;
    logic [CountW-1:0]   nbits;
    logic [BitsW-1:0]    bits;
    logic [IndexW-1:0]   index;
  } s1_t;

  // After value stage: run count, magnitude and target position sum.
  typedef struct packed {
    tok_class_e          tclass;
    logic [CountW-1:0]   nbits;
    logic [BitsW-1:0]    eob;
    logic [MagW-1:0]     mag;
    logic                neg;
    logic [NextW-1:0]    sum;
  } s2_t;

  // Finished result item.
  typedef struct packed {
    logic [CountW-1:0]   extra_bit_count;
    logic                coef_valid;
    logic [IndexW-1:0]   coef_position;
    logic [ValueW-1:0]   coef_value;
    logic [NextW-1:0]    next_index;
    logic                block_done;
    logic [BitsW-1:0]    eob_run;
    logic                overrun;
  } result_t;

  function automatic logic [CountW-1:0] bit_count(input token_e tok);
    logic [CountW-1:0] n;
    unique case (tok)
      TOK_EOB_B2:   n = 4'd2;
      TOK_EOB_B3:   n = 4'd3;
      TOK_EOB_B4:   n = 4'd4;
      TOK_EOB_B12:  n = 4'd12;
      TOK_ZRUN_B3:  n = 4'd3;
      TOK_ZRUN_B6:  n = 4'd6;
      TOK_VAL3, TOK_VAL4, TOK_VAL5, TOK_VAL6: n = 4'd1;
      TOK_CAT3:     n = 4'd2;
      TOK_CAT4:     n = 4'd3;
      TOK_CAT5:     n = 4'd4;
      TOK_CAT6:     n = 4'd5;
      TOK_CAT7:     n = 4'd6;
      TOK_CAT8:     n = 4'd10;
      TOK_RUN1, TOK_RUN2, TOK_RUN3, TOK_RUN4, TOK_RUN5: n = 4'd1;
      TOK_RUN6_B2:  n = 4'd3;
      TOK_RUN10_B3: n = 4'd4;
      TOK_RUN1_V2:  n = 4'd2;
      TOK_RUN2_V2:  n = 4'd3;
      default:      n = 4'd0;
    endcase
    return n;
  endfunction

endpackage

// ===== hw/rtl/dte_decode.sv =====
// First pipeline stage: classify the token, look up its bit count, mask extra bits.
`timescale 1ns / 1ps

module dte_decode (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic [dte_pkg::TokenW-1:0]        token_i,
  input  logic [dte_pkg::BitsW-1:0]         extra_bits_i,
  input  logic [dte_pkg::IndexW-1:0]        coef_index_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output dte_pkg::s1_t                      out_data_o
);

  localparam int unsigned TokenW = dte_pkg::TokenW;

  logic          valid_q;
  dte_pkg::s1_t  data_d, data_q;
  dte_pkg::token_e tok;
  logic [dte_pkg::CountW-1:0] nbits;
  logic [dte_pkg::BitsW-1:0] mask;

  assign tok   = dte_pkg::token_e'(token_i);
  assign nbits = dte_pkg::bit_count(tok);
  assign mask  = dte_pkg::BitsW'(~({(dte_pkg::BitsW+1){1'b1}} << nbits));

  always_comb begin
    data_d.token = tok;
    data_d.nbits = nbits;
    data_d.bits  = extra_bits_i & mask;
    data_d.index = coef_index_i;
    if (token_i <= TokenW'(dte_pkg::TOK_EOB_B12)) begin
      data_d.tclass = dte_pkg::TC_EOB;
    end else if (token_i <= TokenW'(dte_pkg::TOK_ZRUN_B6)) begin
      data_d.tclass = dte_pkg::TC_ZRUN;
    end else begin
      data_d.tclass = dte_pkg::TC_COEF;
    end
  end

  assign in_ready_o = !valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      data_q <= data_d;
    end
  end

  assign out_valid_o = valid_q;
  assign out_data_o  = data_q;

endmodule

// ===== hw/rtl/dte_value.sv =====
// Second pipeline stage: end-of-block run, magnitude, sign and target position sum.
`timescale 1ns / 1ps

module dte_value (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  dte_pkg::s1_t  in_data_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output dte_pkg::s2_t  out_data_o
);

  logic          valid_q;
  dte_pkg::s2_t  data_d, data_q;
  logic [dte_pkg::BitsW-1:0] a;
  logic [4:0]    run;

  assign a = in_data_i.bits;

  always_comb begin
    data_d.tclass = in_data_i.tclass;
    data_d.nbits  = in_data_i.nbits;
    data_d.eob    = '0;
    data_d.mag    = '0;
    data_d.neg    = 1'b0;
    run           = '0;
    case (in_data_i.token)
      dte_pkg::TOK_EOB_0:    data_d.eob = 12'd0;
      dte_pkg::TOK_EOB_1:    data_d.eob = 12'd1;
      dte_pkg::TOK_EOB_2:    data_d.eob = 12'd2;
      dte_pkg::TOK_EOB_B2:   data_d.eob = a + 12'd3;
      dte_pkg::TOK_EOB_B3:   data_d.eob = a + 12'd7;
      dte_pkg::TOK_EOB_B4:   data_d.eob = a + 12'd15;
      dte_pkg::TOK_EOB_B12:  data_d.eob = a - 12'd1;   // zero bits wrap to all blocks
      dte_pkg::TOK_ONE_P:    data_d.mag = 10'd1;
      dte_pkg::TOK_ONE_N:    begin data_d.mag = 10'd1; data_d.neg = 1'b1; end
      dte_pkg::TOK_TWO_P:    data_d.mag = 10'd2;
      dte_pkg::TOK_TWO_N:    begin data_d.mag = 10'd2; data_d.neg = 1'b1; end
      dte_pkg::TOK_VAL3:     begin data_d.mag = 10'd3; data_d.neg = a[0]; end
      dte_pkg::TOK_VAL4:     begin data_d.mag = 10'd4; data_d.neg = a[0]; end
      dte_pkg::TOK_VAL5:     begin data_d.mag = 10'd5; data_d.neg = a[0]; end
      dte_pkg::TOK_VAL6:     begin data_d.mag = 10'd6; data_d.neg = a[0]; end
      dte_pkg::TOK_CAT3:     begin data_d.mag = 10'd7 + 10'(a[0]); data_d.neg = a[1]; end
      dte_pkg::TOK_CAT4:     begin data_d.mag = 10'd9 + 10'(a[1:0]); data_d.neg = a[2]; end
      dte_pkg::TOK_CAT5:     begin data_d.mag = 10'd13 + 10'(a[2:0]); data_d.neg = a[3]; end
      dte_pkg::TOK_CAT6: begin
        data_d.mag = 10'(dte_pkg::Cat6Min) + 10'(a[3:0]);
        data_d.neg = a[4];
      end
      dte_pkg::TOK_CAT7: begin
        data_d.mag = 10'(dte_pkg::Cat7Min) + 10'(a[4:0]);
        data_d.neg = a[5];
      end
      dte_pkg::TOK_CAT8: begin
        data_d.mag = 10'(dte_pkg::Cat8Min) + 10'(a[8:0]);
        data_d.neg = a[9];
      end
      dte_pkg::TOK_RUN1, dte_pkg::TOK_RUN2, dte_pkg::TOK_RUN3,
      dte_pkg::TOK_RUN4, dte_pkg::TOK_RUN5: begin
        run        = 5'(5'd1 + in_data_i.token - 5'(dte_pkg::TokRun1First));
        data_d.mag = 10'd1;
        data_d.neg = a[0];
      end
      dte_pkg::TOK_RUN6_B2: begin
        run = 5'd6 + 5'(a[1:0]); data_d.mag = 10'd1; data_d.neg = a[2];
      end
      dte_pkg::TOK_RUN10_B3: begin
        run = 5'd10 + 5'(a[2:0]); data_d.mag = 10'd1; data_d.neg = a[3];
      end
      dte_pkg::TOK_RUN1_V2: begin
        run = 5'd1; data_d.mag = 10'd2 + 10'(a[0]); data_d.neg = a[1];
      end
      dte_pkg::TOK_RUN2_V2: begin
        run = 5'd2 + 5'(a[0]); data_d.mag = 10'd2 + 10'(a[1]); data_d.neg = a[2];
      end
      default: ;
    endcase
    // Zero runs carry the index past the run; others carry the coefficient target.
    if (in_data_i.tclass == dte_pkg::TC_ZRUN) begin
      data_d.sum = 7'(in_data_i.index) + 7'(a[5:0]) + 7'd1;
    end else begin
      data_d.sum = 7'(in_data_i.index) + 7'(run);
    end
  end

  assign in_ready_o = !valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      data_q <= data_d;
    end
  end

  assign out_valid_o = valid_q;
  assign out_data_o  = data_q;

endmodule

// ===== hw/rtl/dte_finish.sv =====
// Third pipeline stage and output register: overrun check, sign, index saturation.
`timescale 1ns / 1ps

module dte_finish (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  dte_pkg::s2_t      in_data_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output dte_pkg::result_t  out_data_o
);

  logic              valid_q;
  dte_pkg::result_t  data_d, data_q;
  logic [dte_pkg::NextW-1:0]  next;
  logic [dte_pkg::ValueW-1:0] mag_ext;

  assign mag_ext = dte_pkg::ValueW'(in_data_i.mag);

  always_comb begin
    data_d.extra_bit_count = in_data_i.nbits;
    data_d.coef_valid      = 1'b0;
    data_d.coef_position   = '0;
    data_d.coef_value      = '0;
    data_d.eob_run         = '0;
    data_d.overrun         = 1'b0;
    next                   = 7'(dte_pkg::PosEnd);
    case (in_data_i.tclass)
      dte_pkg::TC_EOB: begin
        data_d.eob_run = in_data_i.eob;
      end
      dte_pkg::TC_ZRUN: begin
        if (in_data_i.sum <= 7'(dte_pkg::PosEnd)) begin
          next = in_data_i.sum;
        end
      end
      default: begin
        if (in_data_i.sum > 7'(dte_pkg::LastPos)) begin
          data_d.overrun = 1'b1;
        end else begin
          data_d.coef_valid    = 1'b1;
          data_d.coef_position = in_data_i.sum[5:0];
          // Negate by the two's-complement identity: invert and add one.
          data_d.coef_value    = in_data_i.neg ? (~mag_ext + 11'd1) : mag_ext;
          next                 = in_data_i.sum + 7'd1;
        end
      end
    endcase
    data_d.next_index = next;
    data_d.block_done = (next == 7'(dte_pkg::PosEnd));
  end

  assign in_ready_o = !valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      data_q <= data_d;
    end
  end

  assign out_valid_o = valid_q;
  assign out_data_o  = data_q;

endmodule

// ===== hw/rtl/dct_token_expand_unit.sv =====
// Top level of the DCT token expander: three-stage pipeline with stream ports.
`timescale 1ns / 1ps

// The slave stream takes one Huffman-decoded coefficient token per beat together
// with its extra bits and the block's current zigzag index. The master stream
// returns one result beat per token: the extra bit count, the coefficient write
// (valid, position, signed value), the next index saturated at 64, the
// end-of-block run and an overrun flag. tlast on the master side marks the beat
// that ends a block.
//
// An accepted input beat reaches its result beat on the master side through the
// decode, value and finish stages, each closed by a register. A new beat is
// taken every cycle while slave tready is high; throughput is one token per
// clock, set by the three stage registers with their own valid bits.
//
// Reset clears all stage valid bits, so the master side shows no beat until the
// first token has gone through. When the receiver holds tready low the finish
// register keeps its beat, upstream stages keep filling behind it, and the
// slave tready drops only once all three stages hold a beat.
module dct_token_expand_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [4:0] token, [16:5] extra_bits, [22:17] coef_index, [23] zero
  input  logic [23:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [3:0] extra_bit_count, [4] coef_valid, [10:5] coef_position,
  // [21:11] coef_value, [28:22] next_index, [40:29] eob_run, [41] overrun,
  // [47:42] zero
  output logic [47:0] m_axis_tdata,
  // block_done
  output logic        m_axis_tlast
);

  logic              s1_valid, s1_ready;
  logic              s2_valid, s2_ready;
  dte_pkg::s1_t      s1_data;
  dte_pkg::s2_t      s2_data;
  dte_pkg::result_t  res;

  dte_decode u_decode (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_axis_tvalid),
    .in_ready_o   (s_axis_tready),
    .token_i      (s_axis_tdata[4:0]),
    .extra_bits_i (s_axis_tdata[16:5]),
    .coef_index_i (s_axis_tdata[22:17]),
    .out_valid_o  (s1_valid),
    .out_ready_i  (s1_ready),
    .out_data_o   (s1_data)
  );

  dte_value u_value (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s1_valid),
    .in_ready_o  (s1_ready),
    .in_data_i   (s1_data),
    .out_valid_o (s2_valid),
    .out_ready_i (s2_ready),
    .out_data_o  (s2_data)
  );

  dte_finish u_finish (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s2_valid),
    .in_ready_o  (s2_ready),
    .in_data_i   (s2_data),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_o  (res)
  );

  // Pack the result fields from the lowest bit up.
  assign m_axis_tdata = {6'd0, res.overrun, res.eob_run, res.next_index,
                         res.coef_value, res.coef_position, res.coef_valid,
                         res.extra_bit_count};
  assign m_axis_tlast = res.block_done;

  // A dropped slave tready means every stage is full behind a stalled receiver.
  a_full_only_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> (m_axis_tvalid && !m_axis_tready))
    else $error("input stalled while output side can drain");

  // An overrun never writes a coefficient and always ends the block.
  a_overrun_ends_block: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && res.overrun) |-> (!res.coef_valid && res.block_done))
    else $error("overrun beat writes a coefficient or leaves block open");

  // A written coefficient moves the index just past its position.
  a_coef_advances_index: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && res.coef_valid) |->
      (res.next_index == 7'(res.coef_position) + 7'd1))
    else $error("next index does not follow written coefficient");

  // An end-of-block run is only reported on a beat that closes the block.
  a_eob_run_closes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && res.eob_run != '0) |-> (res.block_done && !res.coef_valid))
    else $error("end-of-block run on a beat that keeps the block open");

endmodule
